/* hdl/olir_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered list package
// Shared types, codes and sizes for the ordered list core and its cells.
// ----------------------------------------------------------------------------
package olir_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 2'd0,
        CMD_INS_TAIL = 2'd1,
        CMD_REMOVE   = 2'd2
    } cmd_e_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic shift_right;
        logic write_tail;
        logic shift_left;
    } cell_ctl_t;

endpackage

/* hdl/ordered_list_insert_remove_core.sv */
// ----------------------------------------------------------------------------
// Ordered list core
// Keeps up to DEPTH signed values in order and serves insert-at-head,
// insert-at-tail and remove-first-match commands.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge where start is high and busy is
// low; req carries the command and the value. Every command produces one
// response transaction on rsp, marked by done for exactly one cycle.
// In the accepting cycle every cell compares its entry with the value and
// registers the match at the accepting edge; in the next cycle busy is
// high, the row of cells shifts or writes and the status is decided. The
// response is on rsp in the cycle after that; a new command may be started
// in that same cycle, but none is taken while busy is high. This order
// follows from the registered compare step and the shift step after it.
// The receiver cannot stall; done marks a response for one cycle only.
// Reset empties the list at once (the count goes to zero); entry contents
// are not cleared, as entries at or beyond the count are never read.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_core
    import olir_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    state_t             state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;
    cell_ctl_t          ctl;
    logic               accept;
    logic               found;
    logic [VALUE_W-1:0] cell_value;

    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [DEPTH:0]     seen;

    assign accept     = start && (state_reg == S_IDLE);
    assign cell_value = accept ? req.value : value_reg;
    assign seen[0]    = 1'b0;
    assign found      = seen[DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [VALUE_W-1:0] left_d;
            logic [VALUE_W-1:0] right_d;

            if (i == 0)
            begin : g_first
                assign left_d = value_reg;
            end
            else
            begin : g_mid
                assign left_d = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[i];
            end
            else
            begin : g_inner
                assign right_d = cell_data[i+1];
            end

            olir_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .value       (cell_value),
                .left_data   (left_d),
                .right_data  (right_d),
                .below_count (count_reg > CNT_W'(i)),
                .is_tail     (count_reg == CNT_W'(i)),
                .seen_in     (seen[i]),
                .seen_out    (seen[i+1]),
                .data        (cell_data[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.command;
            value_reg <= req.value;
        end
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        ctl             = '0;
        ctl.capture     = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next      = S_IDLE;
                done_next       = 1'b1;
                rsp_next.status = ST_OK;
                case (cmd_reg)
                    CMD_INS_HEAD:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            ctl.shift_right = 1'b1;
                            count_next      = count_reg + 1'b1;
                        end
                    end
                    CMD_INS_TAIL:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            ctl.write_tail = 1'b1;
                            count_next     = count_reg + 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.status = ST_EMPTY;
                        end
                        else if (!found)
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            ctl.shift_left = 1'b1;
                            count_next     = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_OK;
                    end
                endcase
                rsp_next.count = COUNT_W'(count_next);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not enter execution");

    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execution did not produce exactly one response");

    a_done_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("response without a preceding execution cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds list depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> (count_reg == $past(count_reg)))
        else $error("entry count changed outside execution");

endmodule

/* hdl/olir_cell.sv */
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry, compares it against the searched value and moves
// data to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module olir_cell
    import olir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [VALUE_W-1:0] value,
    input  logic [VALUE_W-1:0] left_data,
    input  logic [VALUE_W-1:0] right_data,
    input  logic               below_count,
    input  logic               is_tail,
    input  logic               seen_in,
    output logic               seen_out,
    output logic [VALUE_W-1:0] data
);

    logic [VALUE_W-1:0] data_reg;
    logic               match_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift_right)
        begin
            data_reg <= left_data;
        end
        else if (ctl.write_tail && is_tail)
        begin
            data_reg <= value;
        end
        else if (ctl.shift_left && (seen_in || match_reg))
        begin
            data_reg <= right_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            match_reg <= below_count && (data_reg == value);
        end
    end

    assign seen_out = seen_in || match_reg;
    assign data     = data_reg;

endmodule
